>>> src/sdsr_pkg.sv
// ----------------------------------------------------------------------------
// sdsr_pkg
// Shared types, field widths, policy constants and small counter helpers for
// the dead-block / stream-aware RRIP replacement unit.
// ----------------------------------------------------------------------------
package sdsr_pkg;

   // port field widths
   localparam int IDX_W      = 11;
   localparam int PADDR_W    = 48;
   localparam int PC_W       = 48;
   localparam int WAY_PORT_W = 4;
   localparam int THR_W      = 2;

   // parameter defaults
   localparam int NUM_SETS_DEF       = 2048;
   localparam int NUM_WAYS_DEF       = 16;
   localparam int SIGNATURE_BITS_DEF = 5;
   localparam int ADDR_BITS_DEF      = 48;

   // 2-bit saturating counters (RRPV, dead, outcome, monotonic count)
   localparam int CNT_W = 2;
   localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;
   localparam logic [CNT_W-1:0] CNT_MIN = 2'd0;

   // set bits folded into the signature
   localparam int SIG_SET_BITS = 5;

   // reset values
   localparam logic [THR_W-1:0] THR_RESET     = 2'd2;
   localparam logic [CNT_W-1:0] RRPV_RESET    = 2'd2;
   localparam logic [CNT_W-1:0] DEAD_RESET    = 2'd0;
   localparam logic [CNT_W-1:0] OUTCOME_RESET = 2'd1;

   // insertion policy
   localparam logic [CNT_W-1:0] RRPV_DISTANT = 2'd3;
   localparam logic [CNT_W-1:0] RRPV_LONG    = 2'd2;
   localparam logic [CNT_W-1:0] RRPV_NEAR    = 2'd0;
   localparam logic [CNT_W-1:0] DEAD_BYPASS  = 2'd2;
   localparam logic [CNT_W-1:0] DEAD_LONG    = 2'd1;
   localparam logic [CNT_W-1:0] DEAD_HOT     = 2'd0;
   localparam logic [CNT_W-1:0] DEAD_FULL    = 2'd3;
   localparam logic [CNT_W-1:0] OUTCOME_HOT  = 2'd2;

   // control sequencer
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_READ,
      ST_META,
      ST_OLD,
      ST_FIN
   } sdsr_state_type;

   function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] v);
      cnt_inc = (v < CNT_MAX) ? CNT_W'(v + 2'd1) : v;
   endfunction

   function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] v);
      cnt_dec = (v > CNT_MIN) ? CNT_W'(v - 2'd1) : v;
   endfunction

endpackage

>>> src/ship_deadblock_stream_replacement_unit.sv
// ----------------------------------------------------------------------------
// ship_deadblock_stream_replacement_unit
// Cache replacement unit: RRIP with signature-based insertion, dead-block
// counters and a per-set stride stream detector, metadata held in memories.
// ----------------------------------------------------------------------------
// Usage: after reset the unit holds busy high while it clears its memories
// (every set row and every signature entry).
// An access word is taken when start is high and busy is low; the unit then
// holds busy high through set memory read, victim pick and stride update,
// outcome table read-modify-write and set row write-back, preceded by a
// set index reduction when NUM_SETS is not a power of two and below 2048.
// The result word appears on rsp_* for exactly one cycle with rsp_valid, in
// the same cycle that busy drops, and must be captured then: it is never
// held. A new word is taken only once busy has dropped.
// csr_ready is always high; write the threshold only while the unit is idle.
// ----------------------------------------------------------------------------
module ship_deadblock_stream_replacement_unit #(
   parameter int NUM_SETS       = sdsr_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS       = sdsr_pkg::NUM_WAYS_DEF,
   parameter int SIGNATURE_BITS = sdsr_pkg::SIGNATURE_BITS_DEF,
   parameter int ADDR_BITS      = sdsr_pkg::ADDR_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [sdsr_pkg::IDX_W-1:0]      req_set_index,
   input  logic [sdsr_pkg::PADDR_W-1:0]    req_phys_addr,
   input  logic [sdsr_pkg::PC_W-1:0]       req_prog_counter,
   input  logic                           req_is_hit,
   input  logic [sdsr_pkg::WAY_PORT_W-1:0] req_hit_way,
   output logic                           rsp_valid,
   output logic [sdsr_pkg::WAY_PORT_W-1:0] rsp_chosen_way,
   output logic                           rsp_bypass_insert,
   output logic                           rsp_set_streaming,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sdsr_pkg::THR_W-1:0]      csr_wdata
);
   import sdsr_pkg::*;

   localparam int SET_AW      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W       = $clog2(NUM_WAYS);
   localparam int SIG_W       = SIGNATURE_BITS;
   localparam int SIG_ENTRIES = 1 << SIGNATURE_BITS;
   localparam int STRIDE_W    = ADDR_BITS + 1;
   localparam int FLAT_W      = NUM_WAYS * CNT_W;
   localparam int SIGROW_W    = NUM_WAYS * SIG_W;
   localparam int ROW_W       = SIGROW_W + 2 * FLAT_W;
   localparam int STREAM_W    = ADDR_BITS + STRIDE_W + CNT_W;
   localparam int CLR_DEPTH   = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
   localparam int CLR_W       = $clog2(CLR_DEPTH);
   localparam bit SETS_POW2   = ((NUM_SETS & (NUM_SETS - 1)) == 0);
   localparam bit NEED_REDUCE = !SETS_POW2 && (NUM_SETS < (1 << IDX_W));
   localparam int RED_W       = 2 * IDX_W;
   localparam int STEP_W      = $clog2(IDX_W);
   localparam int HW_RED_W    = WAY_PORT_W + WAY_W + 2;

   localparam logic [CLR_W-1:0]  CLR_LAST    = CLR_W'(CLR_DEPTH - 1);
   localparam logic [CLR_W:0]    CLR_SETS    = (CLR_W + 1)'(NUM_SETS);
   localparam logic [CLR_W:0]    CLR_SIGS    = (CLR_W + 1)'(SIG_ENTRIES);
   localparam logic [STEP_W-1:0] STEP_FIRST  = STEP_W'(IDX_W - 1);
   localparam logic [RED_W-1:0]  SETS_RED    = RED_W'(NUM_SETS);
   localparam logic [HW_RED_W-1:0] WAYS_RED  = HW_RED_W'(NUM_WAYS);

   // control registers
   sdsr_state_type    state_ff, state_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // item payload registers
   logic [IDX_W-1:0]     set_rem_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [SIG_W-1:0]     pc_sig_ff;
   logic                 hit_ff;
   logic [WAY_W-1:0]     hit_way_ff;
   logic [SIG_W-1:0]     sig_new_ff;
   logic [WAY_W-1:0]     way_ff;
   logic [SIGROW_W-1:0]  sig_row_ff;
   logic [FLAT_W-1:0]    rrpv_row_ff;
   logic [FLAT_W-1:0]    dead_row_ff;
   logic [SIG_W-1:0]     old_sig_ff;
   logic                 streaming_ff;
   logic                 fwd_hit_ff;
   logic [CNT_W-1:0]     fwd_val_ff;
   logic [WAY_PORT_W-1:0] rsp_way_ff;
   logic                 rsp_bypass_ff;
   logic                 rsp_stream_ff;

   // datapath nets
   logic                 accept;
   logic                 clearing;
   logic [SET_AW-1:0]    set_addr;
   logic [IDX_W-1:0]     rem_next;
   logic [WAY_W-1:0]     hit_way_red;
   logic [SIG_W-1:0]     sig_new;
   logic [ROW_W-1:0]     row_rd;
   logic [STREAM_W-1:0]  stream_rd;
   logic [SIGROW_W-1:0]  sig_flat;
   logic [FLAT_W-1:0]    rrpv_flat;
   logic [FLAT_W-1:0]    dead_flat;
   logic [WAY_W-1:0]     victim_way;
   logic [FLAT_W-1:0]    aged_flat;
   logic [WAY_W-1:0]     way_sel;
   logic [SIG_W-1:0]     old_sig;
   logic [STRIDE_W-1:0]  stride;
   logic [CNT_W-1:0]     mono_new;
   logic                 streaming;
   logic [CNT_W-1:0]     outcome_rd;
   logic [CNT_W-1:0]     outcome_upd;
   logic [CNT_W-1:0]     outcome_new;
   logic                 bypass;
   logic [SIGROW_W-1:0]  sig_wr;
   logic [FLAT_W-1:0]    rrpv_wr;
   logic [FLAT_W-1:0]    dead_wr;

   // memory ports
   logic                 set_rd_en;
   logic                 row_wr_en;
   logic [SET_AW-1:0]    row_wr_addr;
   logic [ROW_W-1:0]     row_wr_data;
   logic                 stream_wr_en;
   logic [SET_AW-1:0]    stream_wr_addr;
   logic [STREAM_W-1:0]  stream_wr_data;
   logic                 sig_rd_en;
   logic [SIG_W-1:0]     sig_rd_addr;
   logic                 sig_wr_en;
   logic [SIG_W-1:0]     sig_wr_addr;
   logic [CNT_W-1:0]     sig_wr_data;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign clearing  = (state_ff == ST_CLEAR);
   assign csr_ready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_way    = rsp_way_ff;
   assign rsp_bypass_insert = rsp_bypass_ff;
   assign rsp_set_streaming = rsp_stream_ff;

   // reduced set index; a single-set cache always maps to row zero
   assign set_addr = (NUM_SETS == 1) ? '0 : SET_AW'(set_rem_ff);

   // one restoring step of set_index mod NUM_SETS
   always_comb begin
      logic [RED_W-1:0] sub;
      logic [RED_W-1:0] rem_ext;
      sub      = SETS_RED << step_ff;
      rem_ext  = RED_W'(set_rem_ff);
      rem_next = (rem_ext >= sub) ? IDX_W'(rem_ext - sub) : set_rem_ff;
   end

   // hit way mod NUM_WAYS on the narrow port value
   always_comb begin
      logic [HW_RED_W-1:0] r;
      logic [HW_RED_W-1:0] sub;
      r = HW_RED_W'(req_hit_way);
      for (int k = WAY_PORT_W - 1; k >= 0; k--) begin
         sub = WAYS_RED << k;
         if (r >= sub) begin
            r = HW_RED_W'(r - sub);
         end
      end
      hit_way_red = WAY_W'(r);
   end

   // PC signature folded with the low set bits
   always_comb begin
      logic [SIG_SET_BITS-1:0] set_low;
      set_low = SIG_SET_BITS'(set_addr);
      sig_new = pc_sig_ff ^ SIG_W'(set_low);
   end

   // unpack the way metadata row
   assign sig_flat  = row_rd[SIGROW_W-1:0];
   assign rrpv_flat = row_rd[SIGROW_W +: FLAT_W];
   assign dead_flat = row_rd[SIGROW_W + FLAT_W +: FLAT_W];

   sdsr_victim_pick #(
      .NUM_WAYS (NUM_WAYS),
      .WAY_W    (WAY_W)
   ) u_victim (
      .rrpv_row   (rrpv_flat),
      .dead_row   (dead_flat),
      .victim_way (victim_way),
      .aged_row   (aged_flat)
   );

   assign way_sel = hit_ff ? hit_way_ff : victim_way;
   assign old_sig = sig_flat[way_sel*SIG_W +: SIG_W];

   // stride detector update
   always_comb begin
      logic [ADDR_BITS-1:0] prev_addr;
      logic [STRIDE_W-1:0]  prev_stride;
      logic [CNT_W-1:0]     mono;
      logic [STRIDE_W-1:0]  diff;
      logic                 prev_nz;
      logic                 rise;
      prev_addr   = stream_rd[ADDR_BITS-1:0];
      prev_stride = stream_rd[ADDR_BITS +: STRIDE_W];
      mono        = stream_rd[ADDR_BITS + STRIDE_W +: CNT_W];
      diff        = {1'b0, addr_ff} - {1'b0, prev_addr};
      prev_nz     = |prev_addr;
      stride      = prev_nz ? diff : '0;
      rise        = prev_nz && (stride == prev_stride) && (|stride);
      mono_new    = rise ? cnt_inc(mono) : cnt_dec(mono);
      streaming   = (mono_new >= thr_ff);
   end

   // outcome counter of the evicted or hit block's signature
   assign outcome_upd = hit_ff ? cnt_inc(outcome_rd) : cnt_dec(outcome_rd);
   // new signature read may land on the entry just written
   assign outcome_new = fwd_hit_ff ? fwd_val_ff : outcome_rd;

   // insertion or promotion of the chosen way
   always_comb begin
      logic [CNT_W-1:0] rrpv_set;
      logic [CNT_W-1:0] dead_set;
      logic [SIG_W-1:0] sig_set;
      bypass  = 1'b0;
      sig_set = sig_row_ff[way_ff*SIG_W +: SIG_W];
      if (hit_ff) begin
         rrpv_set = RRPV_NEAR;
         dead_set = DEAD_HOT;
      end else begin
         sig_set = sig_new_ff;
         if (streaming_ff && (outcome_new < OUTCOME_HOT)) begin
            bypass   = 1'b1;
            rrpv_set = RRPV_DISTANT;
            dead_set = cnt_inc(DEAD_BYPASS);
         end else if (outcome_new >= OUTCOME_HOT) begin
            rrpv_set = RRPV_NEAR;
            dead_set = cnt_inc(DEAD_HOT);
         end else begin
            rrpv_set = RRPV_LONG;
            dead_set = cnt_inc(DEAD_LONG);
         end
      end
      sig_wr  = sig_row_ff;
      rrpv_wr = rrpv_row_ff;
      dead_wr = dead_row_ff;
      sig_wr[way_ff*SIG_W +: SIG_W]   = sig_set;
      rrpv_wr[way_ff*CNT_W +: CNT_W]  = rrpv_set;
      dead_wr[way_ff*CNT_W +: CNT_W]  = dead_set;
   end

   // memory port steering; the clearing pass owns the write ports after reset
   always_comb begin
      logic [SIGROW_W-1:0] sig_rst;
      logic [FLAT_W-1:0]   rrpv_rst;
      logic [FLAT_W-1:0]   dead_rst;
      sig_rst  = '0;
      rrpv_rst = '0;
      dead_rst = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         rrpv_rst[w*CNT_W +: CNT_W] = RRPV_RESET;
         dead_rst[w*CNT_W +: CNT_W] = DEAD_RESET;
      end
      set_rd_en = (state_ff == ST_READ);
      if (clearing) begin
         row_wr_en      = ({1'b0, clr_ff} < CLR_SETS);
         row_wr_addr    = SET_AW'(clr_ff);
         row_wr_data    = {dead_rst, rrpv_rst, sig_rst};
         stream_wr_en   = row_wr_en;
         stream_wr_addr = SET_AW'(clr_ff);
         stream_wr_data = '0;
         sig_wr_en      = ({1'b0, clr_ff} < CLR_SIGS);
         sig_wr_addr    = SIG_W'(clr_ff);
         sig_wr_data    = OUTCOME_RESET;
      end else begin
         row_wr_en      = (state_ff == ST_FIN);
         row_wr_addr    = set_addr;
         row_wr_data    = {dead_wr, rrpv_wr, sig_wr};
         stream_wr_en   = (state_ff == ST_META);
         stream_wr_addr = set_addr;
         stream_wr_data = {mono_new, stride, addr_ff};
         sig_wr_en      = (state_ff == ST_OLD);
         sig_wr_addr    = old_sig_ff;
         sig_wr_data    = outcome_upd;
      end
      sig_rd_en   = (state_ff == ST_META) || (state_ff == ST_OLD);
      sig_rd_addr = (state_ff == ST_META) ? old_sig : sig_new_ff;
   end

   sdsr_set_store #(
      .DEPTH    (NUM_SETS),
      .AW       (SET_AW),
      .ROW_W    (ROW_W),
      .STREAM_W (STREAM_W)
   ) u_set_store (
      .clock          (clock),
      .rd_en          (set_rd_en),
      .rd_addr        (set_addr),
      .row_rd_data    (row_rd),
      .stream_rd_data (stream_rd),
      .row_wr_en      (row_wr_en),
      .row_wr_addr    (row_wr_addr),
      .row_wr_data    (row_wr_data),
      .stream_wr_en   (stream_wr_en),
      .stream_wr_addr (stream_wr_addr),
      .stream_wr_data (stream_wr_data)
   );

   sdsr_sig_table #(
      .AW (SIG_W)
   ) u_sig_table (
      .clock   (clock),
      .rd_en   (sig_rd_en),
      .rd_addr (sig_rd_addr),
      .rd_data (outcome_rd),
      .wr_en   (sig_wr_en),
      .wr_addr (sig_wr_addr),
      .wr_data (sig_wr_data)
   );

   // sequencer: next state and counters
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      thr_in       = csr_valid ? csr_wdata : thr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = CLR_W'(clr_ff + 1'b1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               step_in  = STEP_FIRST;
               state_in = NEED_REDUCE ? ST_REDUCE : ST_READ;
            end
         end
         ST_REDUCE: begin
            step_in = STEP_W'(step_ff - 1'b1);
            if (step_ff == '0) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_META;
         ST_META: state_in = ST_OLD;
         ST_OLD:  state_in = ST_FIN;
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the access word and advance the item through its steps
   always_ff @(posedge clock) begin
      if (accept) begin
         set_rem_ff <= req_set_index;
         addr_ff    <= ADDR_BITS'(req_phys_addr);
         pc_sig_ff  <= req_prog_counter[SIG_W+1:2];
         hit_ff     <= req_is_hit;
         hit_way_ff <= hit_way_red;
      end
      if (state_ff == ST_REDUCE) begin
         set_rem_ff <= rem_next;
      end
      if (state_ff == ST_READ) begin
         sig_new_ff <= sig_new;
      end
      if (state_ff == ST_META) begin
         way_ff       <= way_sel;
         sig_row_ff   <= sig_flat;
         rrpv_row_ff  <= hit_ff ? rrpv_flat : aged_flat;
         dead_row_ff  <= dead_flat;
         old_sig_ff   <= old_sig;
         streaming_ff <= streaming;
      end
      if (state_ff == ST_OLD) begin
         fwd_hit_ff <= (sig_new_ff == old_sig_ff);
         fwd_val_ff <= outcome_upd;
      end
      if (state_ff == ST_FIN) begin
         rsp_way_ff    <= WAY_PORT_W'(way_ff);
         rsp_bypass_ff <= bypass;
         rsp_stream_ff <= streaming_ff;
      end
   end

endmodule

>>> src/sdsr_set_store.sv
// ----------------------------------------------------------------------------
// sdsr_set_store
// Per-set metadata memories: one row of way metadata (signature, RRPV, dead
// counter for every way) and one row of stride detector state.
// ----------------------------------------------------------------------------
module sdsr_set_store #(
   parameter int DEPTH    = sdsr_pkg::NUM_SETS_DEF,
   parameter int AW       = 11,
   parameter int ROW_W    = 144,
   parameter int STREAM_W = 99
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [ROW_W-1:0]    row_rd_data,
   output logic [STREAM_W-1:0] stream_rd_data,
   input  logic                row_wr_en,
   input  logic [AW-1:0]       row_wr_addr,
   input  logic [ROW_W-1:0]    row_wr_data,
   input  logic                stream_wr_en,
   input  logic [AW-1:0]       stream_wr_addr,
   input  logic [STREAM_W-1:0] stream_wr_data
);
   import sdsr_pkg::*;

   logic [ROW_W-1:0]    row_mem    [DEPTH];
   logic [STREAM_W-1:0] stream_mem [DEPTH];

   // way metadata row
   always_ff @(posedge clock) begin
      if (row_wr_en) begin
         row_mem[row_wr_addr] <= row_wr_data;
      end
      if (rd_en) begin
         row_rd_data <= row_mem[rd_addr];
      end
   end

   // stride detector row
   always_ff @(posedge clock) begin
      if (stream_wr_en) begin
         stream_mem[stream_wr_addr] <= stream_wr_data;
      end
      if (rd_en) begin
         stream_rd_data <= stream_mem[rd_addr];
      end
   end

endmodule

>>> src/sdsr_sig_table.sv
// ----------------------------------------------------------------------------
// sdsr_sig_table
// Signature outcome table: one 2-bit reuse counter per PC signature.
// ----------------------------------------------------------------------------
module sdsr_sig_table #(
   parameter int AW = sdsr_pkg::SIGNATURE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [sdsr_pkg::CNT_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [sdsr_pkg::CNT_W-1:0] wr_data
);
   import sdsr_pkg::*;

   localparam int ENTRIES = 1 << AW;

   logic [CNT_W-1:0] outcome_mem [ENTRIES];

   // read-first table, one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         outcome_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= outcome_mem[rd_addr];
      end
   end

endmodule

>>> src/sdsr_victim_pick.sv
// ----------------------------------------------------------------------------
// sdsr_victim_pick
// Victim selection over one set: dead and distant first, then any dead way,
// else age every RRPV until one reaches distant and take the lowest such way.
// ----------------------------------------------------------------------------
module sdsr_victim_pick #(
   parameter int NUM_WAYS = sdsr_pkg::NUM_WAYS_DEF,
   parameter int WAY_W    = 4
) (
   input  logic [NUM_WAYS*sdsr_pkg::CNT_W-1:0] rrpv_row,
   input  logic [NUM_WAYS*sdsr_pkg::CNT_W-1:0] dead_row,
   output logic [WAY_W-1:0]                    victim_way,
   output logic [NUM_WAYS*sdsr_pkg::CNT_W-1:0] aged_row
);
   import sdsr_pkg::*;

   always_comb begin
      logic             found_dd;
      logic             found_d;
      logic [WAY_W-1:0] way_dd;
      logic [WAY_W-1:0] way_d;
      logic [WAY_W-1:0] way_age;
      logic             any3;
      logic             any2;
      logic             any1;
      logic [CNT_W-1:0] top;
      logic [CNT_W-1:0] add;
      logic [CNT_W-1:0] rv;
      logic [CNT_W-1:0] dv;
      logic [CNT_W-1:0] av;
      found_dd = 1'b0;
      found_d  = 1'b0;
      way_dd   = '0;
      way_d    = '0;
      way_age  = '0;
      any3     = 1'b0;
      any2     = 1'b0;
      any1     = 1'b0;
      // scan dead ways; walk downward so the lowest match wins
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         rv = rrpv_row[w*CNT_W +: CNT_W];
         dv = dead_row[w*CNT_W +: CNT_W];
         if (dv == DEAD_FULL && rv == RRPV_DISTANT) begin
            found_dd = 1'b1;
            way_dd   = WAY_W'(w);
         end
         if (dv == DEAD_FULL) begin
            found_d = 1'b1;
            way_d   = WAY_W'(w);
         end
         any3 = any3 | (rv == 2'd3);
         any2 = any2 | (rv == 2'd2);
         any1 = any1 | (rv == 2'd1);
      end
      // largest RRPV in the set sets the aging step
      if (any3) begin
         top = 2'd3;
      end else if (any2) begin
         top = 2'd2;
      end else if (any1) begin
         top = 2'd1;
      end else begin
         top = 2'd0;
      end
      add = CNT_W'(RRPV_DISTANT - top);
      // age the set; the first way at distant becomes the fallback victim
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         av = CNT_W'(rrpv_row[w*CNT_W +: CNT_W] + add);
         aged_row[w*CNT_W +: CNT_W] = (found_d) ? rrpv_row[w*CNT_W +: CNT_W] : av;
         if (av == RRPV_DISTANT) begin
            way_age = WAY_W'(w);
         end
      end
      if (found_dd) begin
         victim_way = way_dd;
      end else if (found_d) begin
         victim_way = way_d;
      end else begin
         victim_way = way_age;
      end
   end

endmodule

>>> tb/sdsr_replacement_checker.sv
// ----------------------------------------------------------------------------
// sdsr_replacement_checker
// Watches the access, result and threshold channels of the replacement unit.
// Keeps its own copy of the RRIP, signature, dead-block and stride-detector
// state, works out the way, bypass flag and streaming flag of every accepted
// access word, and compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module sdsr_replacement_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [sdsr_pkg::IDX_W-1:0]      req_set_index,
   input  logic [sdsr_pkg::PADDR_W-1:0]    req_phys_addr,
   input  logic [sdsr_pkg::PC_W-1:0]       req_prog_counter,
   input  logic                            req_is_hit,
   input  logic [sdsr_pkg::WAY_PORT_W-1:0] req_hit_way,
   input  logic                            rsp_valid,
   input  logic [sdsr_pkg::WAY_PORT_W-1:0] rsp_chosen_way,
   input  logic                            rsp_bypass_insert,
   input  logic                            rsp_set_streaming,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [sdsr_pkg::THR_W-1:0]      csr_wdata,
   output int                              error_count,
   output int                              words_pending,
   output int                              words_checked,
   output int                              hit_words,
   output int                              bypass_words,
   output int                              streaming_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import sdsr_pkg::*;

   localparam int NSETS  = NUM_SETS_DEF;
   localparam int NWAYS  = NUM_WAYS_DEF;
   localparam int SIG_W  = SIGNATURE_BITS_DEF;
   localparam int BLOCKS = NSETS * NWAYS;
   localparam int SIGS   = 1 << SIG_W;

   typedef struct packed {
      logic [WAY_PORT_W-1:0] way;
      logic                  bypass;
      logic                  streaming;
   } placement_type;

   // shadow of the unit's metadata
   logic [SIG_W-1:0]   shadow_sig    [BLOCKS];
   logic [CNT_W-1:0]   block_rrpv    [BLOCKS];
   logic [CNT_W-1:0]   block_dead    [BLOCKS];
   logic [CNT_W-1:0]   outcome_ctr   [SIGS];
   logic [PADDR_W-1:0] set_prev_addr [NSETS];
   logic [PADDR_W:0]   set_prev_step [NSETS];
   logic [CNT_W-1:0]   mono_count    [NSETS];
   logic [THR_W-1:0]   stream_thr;

   placement_type placement_queue[$];
   int errors, checked, hits, bypasses, streams;

   // Apply one access to the shadow state and return the placement it yields.
   task automatic place_access(input logic [IDX_W-1:0] set_in,
                               input logic [PADDR_W-1:0] addr,
                               input logic [PC_W-1:0] pc,
                               input logic hit,
                               input logic [WAY_PORT_W-1:0] way_in,
                               output placement_type res);
      int set, base, way, w;
      bit found;
      logic [CNT_W-1:0] oldest;
      logic [PADDR_W:0] stride;
      logic [SIG_W-1:0] sig, old_sig;
      logic [SIG_SET_BITS-1:0] set_bits;
      logic streaming, bypass;
      set = int'(set_in) % NSETS;
      base = set * NWAYS;
      bypass = 1'b0;
      way = 0;
      if (hit) begin
         way = int'(way_in) % NWAYS;
      end else begin
         // dead and distant first, then any dead way
         found = 1'b0;
         for (w = 0; w < NWAYS; w++)
            if (!found && block_dead[base+w] == CNT_MAX && block_rrpv[base+w] == RRPV_DISTANT) begin
               way = w;
               found = 1'b1;
            end
         for (w = 0; w < NWAYS; w++)
            if (!found && block_dead[base+w] == CNT_MAX) begin
               way = w;
               found = 1'b1;
            end
         // age the whole set until some way is distant
         if (!found) begin
            oldest = CNT_MIN;
            for (w = 0; w < NWAYS; w++)
               if (block_rrpv[base+w] > oldest) oldest = block_rrpv[base+w];
            if (oldest < RRPV_DISTANT)
               for (w = 0; w < NWAYS; w++)
                  block_rrpv[base+w] = block_rrpv[base+w] + (RRPV_DISTANT - oldest);
            for (w = NWAYS - 1; w >= 0; w--)
               if (block_rrpv[base+w] == RRPV_DISTANT) way = w;
         end
      end

      // stride detector
      if (set_prev_addr[set] == '0) stride = '0;
      else stride = {1'b0, addr} - {1'b0, set_prev_addr[set]};
      if (set_prev_addr[set] != '0 && stride == set_prev_step[set] && stride != '0) begin
         if (mono_count[set] < CNT_MAX) mono_count[set] = mono_count[set] + 1'b1;
      end else begin
         if (mono_count[set] > CNT_MIN) mono_count[set] = mono_count[set] - 1'b1;
      end
      set_prev_addr[set] = addr;
      set_prev_step[set] = stride;
      streaming = (mono_count[set] >= stream_thr);

      set_bits = set[SIG_SET_BITS-1:0];
      sig = SIG_W'((pc >> 2) ^ PC_W'(set_bits));
      old_sig = shadow_sig[base+way];

      if (hit) begin
         // promote and reward the stored signature
         block_rrpv[base+way] = RRPV_NEAR;
         block_dead[base+way] = DEAD_HOT;
         if (outcome_ctr[old_sig] < CNT_MAX) outcome_ctr[old_sig] = outcome_ctr[old_sig] + 1'b1;
      end else begin
         // penalize the victim, then insert the new block
         if (outcome_ctr[old_sig] > CNT_MIN) outcome_ctr[old_sig] = outcome_ctr[old_sig] - 1'b1;
         shadow_sig[base+way] = sig;
         if (streaming && outcome_ctr[sig] < OUTCOME_HOT) begin
            bypass = 1'b1;
            block_rrpv[base+way] = RRPV_DISTANT;
            block_dead[base+way] = DEAD_BYPASS;
         end else if (outcome_ctr[sig] >= OUTCOME_HOT) begin
            block_rrpv[base+way] = RRPV_NEAR;
            block_dead[base+way] = DEAD_HOT;
         end else begin
            block_rrpv[base+way] = RRPV_LONG;
            block_dead[base+way] = DEAD_LONG;
         end
         if (block_dead[base+way] < DEAD_FULL) block_dead[base+way] = block_dead[base+way] + 1'b1;
      end

      res.way = WAY_PORT_W'(way);
      res.bypass = bypass;
      res.streaming = streaming;
   endtask

   always @(posedge clock) begin
      placement_type want, got;
      if (reset) begin
         // clear the shadow to its power-up contents
         for (int i = 0; i < BLOCKS; i++) begin
            shadow_sig[i] = '0;
            block_rrpv[i] = RRPV_RESET;
            block_dead[i] = DEAD_RESET;
         end
         for (int i = 0; i < SIGS; i++) outcome_ctr[i] = OUTCOME_RESET;
         for (int i = 0; i < NSETS; i++) begin
            set_prev_addr[i] = '0;
            set_prev_step[i] = '0;
            mono_count[i] = CNT_MIN;
         end
         stream_thr = THR_RESET;
         placement_queue.delete();
         errors = 0;
         checked = 0;
         hits = 0;
         bypasses = 0;
         streams = 0;
      end else begin
         // check a result word against the oldest prediction
         if (rsp_valid) begin
            got.way = rsp_chosen_way;
            got.bypass = rsp_bypass_insert;
            got.streaming = rsp_set_streaming;
            if (placement_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word way=%0d bypass=%0b streaming=%0b",
                        $time, got.way, got.bypass, got.streaming);
            end else begin
               want = placement_queue.pop_front();
               checked++;
               if (got.way !== want.way) begin
                  errors++;
                  $display("%0t: chosen_way expected %0d actual %0d",
                           $time, want.way, got.way);
               end
               if (got.bypass !== want.bypass) begin
                  errors++;
                  $display("%0t: bypass_insert expected %0b actual %0b",
                           $time, want.bypass, got.bypass);
               end
               if (got.streaming !== want.streaming) begin
                  errors++;
                  $display("%0t: set_streaming expected %0b actual %0b",
                           $time, want.streaming, got.streaming);
               end
               if (want.bypass) bypasses++;
               if (want.streaming) streams++;
            end
         end
         // predict an accepted access word
         if (start && !busy) begin
            place_access(req_set_index, req_phys_addr, req_prog_counter,
                         req_is_hit, req_hit_way, want);
            placement_queue.push_back(want);
            if (req_is_hit) hits++;
         end
         // track the threshold register
         if (csr_valid && csr_ready) stream_thr = csr_wdata;
      end
      error_count     <= errors;
      words_pending   <= placement_queue.size();
      words_checked   <= checked;
      hit_words       <= hits;
      bypass_words    <= bypasses;
      streaming_words <= streams;
   end

endmodule

>>> tb/tb_ship_deadblock_stream_replacement_unit.sv
// ----------------------------------------------------------------------------
// tb_ship_deadblock_stream_replacement_unit
// Drives directed and random access words into the replacement unit under
// several stream thresholds, with random sender gaps and full drains, while
// the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_ship_deadblock_stream_replacement_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import sdsr_pkg::*;

   localparam time HALF_PERIOD      = 10ns;
   localparam int  RESET_CYCLES     = 6;
   localparam int  SETTLE_CYCLES    = 10;
   localparam int  LANES            = 8;
   localparam int  PHASE_WORDS      = 400;
   localparam int  PHASES           = 5;
   localparam time RUN_LIMIT        = 10ms;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [IDX_W-1:0]      req_set_index = '0;
   logic [PADDR_W-1:0]    req_phys_addr = '0;
   logic [PC_W-1:0]       req_prog_counter = '0;
   logic                  req_is_hit = 1'b0;
   logic [WAY_PORT_W-1:0] req_hit_way = '0;
   logic                  rsp_valid;
   logic [WAY_PORT_W-1:0] rsp_chosen_way;
   logic                  rsp_bypass_insert;
   logic                  rsp_set_streaming;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [THR_W-1:0]      csr_wdata = '0;

   int error_count, words_pending, words_checked, hit_words, bypass_words, streaming_words;
   int threshold_writes = 0;
   bit quiet_burst = 1'b0;

   // per-lane stride streams and a small PC pool
   logic [IDX_W-1:0]   lane_set    [LANES];
   logic [PADDR_W-1:0] lane_addr   [LANES];
   logic [PADDR_W-1:0] lane_stride [LANES];
   logic [PC_W-1:0]    lane_pc     [LANES];
   logic [PC_W-1:0]    pc_pool     [LANES];

   always #(HALF_PERIOD) clock = ~clock;

   ship_deadblock_stream_replacement_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_set_index     (req_set_index),
      .req_phys_addr     (req_phys_addr),
      .req_prog_counter  (req_prog_counter),
      .req_is_hit        (req_is_hit),
      .req_hit_way       (req_hit_way),
      .rsp_valid         (rsp_valid),
      .rsp_chosen_way    (rsp_chosen_way),
      .rsp_bypass_insert (rsp_bypass_insert),
      .rsp_set_streaming (rsp_set_streaming),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   sdsr_replacement_checker placement_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_set_index     (req_set_index),
      .req_phys_addr     (req_phys_addr),
      .req_prog_counter  (req_prog_counter),
      .req_is_hit        (req_is_hit),
      .req_hit_way       (req_hit_way),
      .rsp_valid         (rsp_valid),
      .rsp_chosen_way    (rsp_chosen_way),
      .rsp_bypass_insert (rsp_bypass_insert),
      .rsp_set_streaming (rsp_set_streaming),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .error_count       (error_count),
      .words_pending     (words_pending),
      .words_checked     (words_checked),
      .hit_words         (hit_words),
      .bypass_words      (bypass_words),
      .streaming_words   (streaming_words)
   );

   function automatic logic [PADDR_W-1:0] rand48();
      return PADDR_W'({$urandom(), $urandom()});
   endfunction

   // Present one access word after a random gap and hold until it is taken.
   task automatic send_access(input logic [IDX_W-1:0] set_idx,
                              input logic [PADDR_W-1:0] addr,
                              input logic [PC_W-1:0] pc,
                              input logic hit,
                              input logic [WAY_PORT_W-1:0] way);
      int gap;
      gap = quiet_burst ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_set_index    <= set_idx;
      req_phys_addr    <= addr;
      req_prog_counter <= pc;
      req_is_hit       <= hit;
      req_hit_way      <= way;
      start            <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop start and hold until every predicted word has come back.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (words_pending != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      threshold_writes++;
   endtask

   // Mostly stride streams on a few sets, then reuse noise, then anything.
   task automatic random_access();
      int kind, lane, pick;
      logic hit;
      logic [WAY_PORT_W-1:0] way;
      logic [PADDR_W-1:0] step;
      kind = $urandom_range(0, 99);
      hit = ($urandom_range(0, 99) < 30);
      way = WAY_PORT_W'($urandom_range(0, 15));
      lane = $urandom_range(0, LANES - 1);
      pick = $urandom_range(0, LANES - 1);
      if (kind < 60) begin
         if ($urandom_range(0, 15) == 0) begin
            step = PADDR_W'($urandom_range(1, 8)) << 6;
            lane_stride[lane] = $urandom_range(0, 1) ? step : -step;
         end
         lane_addr[lane] = lane_addr[lane] + lane_stride[lane];
         send_access(lane_set[lane], lane_addr[lane], lane_pc[lane], hit, way);
      end else if (kind < 85) begin
         send_access(lane_set[lane], PADDR_W'($urandom_range(0, 4095)) << 6,
                     pc_pool[pick], hit, way);
      end else begin
         send_access(IDX_W'($urandom()), rand48(), rand48(), 1'($urandom_range(0, 1)), way);
      end
   endtask

   // Stop a hung run.
   initial begin
      #(RUN_LIMIT);
      $display("ship_deadblock_stream_replacement_unit test failed");
      $finish;
   end

   initial begin
      logic [THR_W-1:0] phase_thr [PHASES];
      logic [PC_W-1:0] stream_pc;
      phase_thr = '{2'd3, 2'd0, 2'd1, 2'd3, 2'd0};
      for (int i = 0; i < LANES; i++) begin
         lane_set[i]    = IDX_W'($urandom());
         lane_addr[i]   = rand48() & ~PADDR_W'(63);
         lane_stride[i] = PADDR_W'($urandom_range(1, 4)) << 6;
         lane_pc[i]     = rand48();
         pc_pool[i]     = rand48();
      end
      // signature of this PC in set 5 is nonzero, so it keeps a weak outcome
      stream_pc = 48'h0000_0040_0010;

      // hold reset, then wait out the clearing pass
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();
      write_threshold(THR_RESET);

      // directed: field extremes, hits on the end ways
      send_access('0, '0, '0, 1'b0, '0);
      send_access('1, '1, '1, 1'b0, '0);
      send_access('1, '1, '1, 1'b1, '1);
      send_access('0, 48'h40, '0, 1'b1, '0);
      // directed: ascending stride until the set streams and bypasses
      for (int i = 0; i < 8; i++)
         send_access(11'd5, 48'h1_0000 + 48'(i * 64), stream_pc, 1'b0, '0);
      send_access(11'd5, 48'h2_0000, stream_pc, 1'b1, 4'd3);
      // directed: descending stride
      for (int i = 0; i < 6; i++)
         send_access(11'd6, 48'h8_0000 - 48'(i * 128), pc_pool[0], 1'b0, '0);
      // directed: stride across the top of the address space and through zero
      send_access(11'd7, 48'hFFFF_FFFF_FFC0, pc_pool[1], 1'b0, '0);
      send_access(11'd7, '0, pc_pool[1], 1'b0, '0);
      send_access(11'd7, 48'h40, pc_pool[1], 1'b0, '0);

      // random phases, one threshold each, with a full drain halfway through
      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_threshold(phase_thr[p]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 32 == 0) quiet_burst = ($urandom_range(0, 3) == 0);
            if (n == PHASE_WORDS / 2) settle();
            random_access();
         end
      end
      quiet_burst = 1'b0;
      settle();

      $display("Covered %0d access words (%0d hits) over %0d threshold settings;",
               words_checked, hit_words, threshold_writes);
      $display("%0d results streamed and %0d were streaming bypass inserts.",
               streaming_words, bypass_words);
      if (error_count == 0 && words_pending == 0) begin
         $display("ship_deadblock_stream_replacement_unit test passed");
      end else begin
         $display("ship_deadblock_stream_replacement_unit test failed");
      end
      $finish;
   end

endmodule
